// File: src/utf8_sanitizer_macros.svh
// ----------------------------------------------------------------------------
// utf8_sanitizer assertion macros
// clocked assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZER_MACROS_SVH
`define UTF8_SANITIZER_MACROS_SVH

// property checked outside reset
`define UTF8S_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// property checked at every edge, reset included
`define UTF8S_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// utf8s_pkg
// constants, types and helper functions of the utf8 sanitizer
// ----------------------------------------------------------------------------
package utf8s_pkg;

    localparam int RUN_DEPTH  = 6;
    localparam int HELD_DEPTH = 3;
    localparam int RUN_CNT_W  = $clog2(RUN_DEPTH + 1);

    localparam logic [7:0] CONT_MIN   = 8'h80;
    localparam logic [7:0] CONT_MAX   = 8'hBF;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_E0   = 8'hE0;
    localparam logic [7:0] E0_MIN     = 8'hA0;
    localparam logic [7:0] LEAD3_ED   = 8'hED;
    localparam logic [7:0] ED_MAX     = 8'h9F;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_F0   = 8'hF0;
    localparam logic [7:0] F0_MIN     = 8'h90;
    localparam logic [7:0] LEAD4_F4   = 8'hF4;
    localparam logic [7:0] F4_MAX     = 8'h8F;

    localparam logic [7:0] FFFD_B0    = 8'hEF;
    localparam logic [7:0] FFFD_B1    = 8'hBF;
    localparam logic [7:0] FFFD_B2    = 8'hBD;

    localparam logic [2:0] LEN_NONE   = 3'd0;
    localparam logic [2:0] LEN_TWO    = 3'd2;
    localparam logic [2:0] LEN_THREE  = 3'd3;
    localparam logic [2:0] LEN_FOUR   = 3'd4;

    typedef struct packed {
        logic       ok;
        logic [2:0] len;
        logic [7:0] lo;
        logic [7:0] hi;
    } lead_t;

    // one result entry: {any_replaced, byte}
    typedef struct packed {
        logic [RUN_DEPTH-1:0][8:0] ent;
        logic [RUN_CNT_W-1:0]      cnt;
    } run_t;

    function automatic lead_t classify_lead(logic [7:0] c);
        lead_t l;
        l.ok  = 1'b1;
        l.len = LEN_NONE;
        l.lo  = CONT_MIN;
        l.hi  = CONT_MAX;
        if (c >= LEAD2_MIN && c <= LEAD2_MAX) begin
            l.len = LEN_TWO;
        end else if (c == LEAD3_E0) begin
            l.len = LEN_THREE;
            l.lo  = E0_MIN;
        end else if (c == LEAD3_ED) begin
            l.len = LEN_THREE;
            l.hi  = ED_MAX;
        end else if (c > LEAD3_E0 && c <= LEAD3_MAX) begin
            l.len = LEN_THREE;
        end else if (c == LEAD4_F0) begin
            l.len = LEN_FOUR;
            l.lo  = F0_MIN;
        end else if (c == LEAD4_F4) begin
            l.len = LEN_FOUR;
            l.hi  = F4_MAX;
        end else if (c > LEAD4_F0 && c < LEAD4_F4) begin
            l.len = LEN_FOUR;
        end else begin
            l.ok  = 1'b0;
        end
        return l;
    endfunction

    function automatic run_t run_push(run_t r, logic [7:0] b, logic rep);
        run_t o;
        o = r;
        if (r.cnt < RUN_CNT_W'(RUN_DEPTH)) begin
            o.ent[r.cnt] = {rep, b};
            o.cnt        = r.cnt + RUN_CNT_W'(1);
        end
        return o;
    endfunction

    function automatic run_t run_push_fffd(run_t r);
        run_t o;
        o = run_push(r, FFFD_B0, 1'b1);
        o = run_push(o, FFFD_B1, 1'b1);
        o = run_push(o, FFFD_B2, 1'b1);
        return o;
    endfunction

endpackage

// File: src/utf8_sanitizer.sv
// ----------------------------------------------------------------------------
// utf8_sanitizer
// streaming utf-8 repair: well-formed text passes through, each maximal
// ill-formed subpart becomes U+FFFD (EF BF BD)
//
// input channel s_*: one raw byte per request, s_in_last on the final byte
// of a text. result channel m_*: one output byte per request, m_run_last on
// the last byte caused by an input, m_text_end on the final byte of a text,
// m_any_replaced sticky within the text.
// an accepted byte is decoded in the same cycle and its 0 to 6 result bytes
// land in a result register; the first one is shown in the next cycle.
// the result register drains one byte per cycle while m_ready is high.
// throughput: one input per cycle while each input gives at most one byte
// and m_ready is high; an input giving more bytes holds the input side until
// its last byte is taken. held-back bytes of a partial sequence give no result.
// a stalled receiver holds the current result; the input is accepted again
// in the cycle the last pending result is taken.
// reset clears the pending sequence and the replacement flag and empties the
// result register; m_valid is low in the cycle after reset.
// ----------------------------------------------------------------------------
module utf8_sanitizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_text_end,
    output logic       m_any_replaced
);
    import utf8s_pkg::*;

    logic [7:0]           held_reg [HELD_DEPTH];
    logic [7:0]           held_next [HELD_DEPTH];
    logic [1:0]           held_cnt_reg, held_cnt_next;
    logic [2:0]           exp_len_reg, exp_len_next;
    logic [7:0]           sec_min_reg, sec_min_next;
    logic [7:0]           sec_max_reg, sec_max_next;
    logic                 replaced_reg, replaced_next;

    logic [RUN_DEPTH-1:0][8:0] run_ent_reg;
    logic [RUN_CNT_W-1:0] run_cnt_reg;
    logic [RUN_CNT_W-1:0] run_idx_reg;
    logic                 run_end_reg;

    run_t                 run_next;
    lead_t                lead;
    logic [7:0]           in_lo, in_hi;
    logic                 do_fresh;
    logic                 rep;
    logic                 last_pos;
    logic                 s_fire, m_fire;
    logic [8:0]           cur_ent;

    // decode of one input byte against the pending sequence
    always_comb begin
        run_next      = '0;
        rep           = replaced_reg;
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        exp_len_next  = exp_len_reg;
        sec_min_next  = sec_min_reg;
        sec_max_next  = sec_max_reg;
        do_fresh      = 1'b0;
        lead          = classify_lead(s_in_byte);
        in_lo         = (held_cnt_reg == 2'd1) ? sec_min_reg : CONT_MIN;
        in_hi         = (held_cnt_reg == 2'd1) ? sec_max_reg : CONT_MAX;

        if (held_cnt_reg == 2'd0) begin
            do_fresh = 1'b1;
        end else if (s_in_byte >= in_lo && s_in_byte <= in_hi) begin
            if ({1'b0, held_cnt_reg} + 3'd1 >= exp_len_reg) begin
                for (int k = 0; k < HELD_DEPTH; k++) begin
                    if (2'(k) < held_cnt_reg) begin
                        run_next = run_push(run_next, held_reg[k], rep);
                    end
                end
                run_next      = run_push(run_next, s_in_byte, rep);
                held_cnt_next = 2'd0;
                exp_len_next  = LEN_NONE;
                sec_min_next  = CONT_MIN;
                sec_max_next  = CONT_MAX;
            end else begin
                held_next[held_cnt_reg] = s_in_byte;
                held_cnt_next           = held_cnt_reg + 2'd1;
            end
        end else begin
            // broken sequence: flush one replacement, then retry the byte
            rep           = 1'b1;
            run_next      = run_push_fffd(run_next);
            held_cnt_next = 2'd0;
            exp_len_next  = LEN_NONE;
            sec_min_next  = CONT_MIN;
            sec_max_next  = CONT_MAX;
            do_fresh      = 1'b1;
        end

        if (do_fresh) begin
            if (!s_in_byte[7]) begin
                run_next = run_push(run_next, s_in_byte, rep);
            end else if (lead.ok) begin
                held_next[0]  = s_in_byte;
                held_cnt_next = 2'd1;
                exp_len_next  = lead.len;
                sec_min_next  = lead.lo;
                sec_max_next  = lead.hi;
            end else begin
                rep      = 1'b1;
                run_next = run_push_fffd(run_next);
            end
        end

        replaced_next = rep;
        if (s_in_last) begin
            if (held_cnt_next != 2'd0) begin
                run_next = run_push_fffd(run_next);
            end
            held_cnt_next = 2'd0;
            exp_len_next  = LEN_NONE;
            sec_min_next  = CONT_MIN;
            sec_max_next  = CONT_MAX;
            replaced_next = 1'b0;
        end
    end

    assign m_valid        = (run_idx_reg != run_cnt_reg);
    assign last_pos       = (run_idx_reg + RUN_CNT_W'(1) == run_cnt_reg);
    assign cur_ent        = run_ent_reg[run_idx_reg];
    assign m_out_byte     = cur_ent[7:0];
    assign m_any_replaced = cur_ent[8];
    assign m_run_last     = last_pos;
    assign m_text_end     = last_pos && run_end_reg;
    assign s_ready        = !m_valid || (m_ready && last_pos);
    assign s_fire         = s_valid && s_ready;
    assign m_fire         = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt_reg <= 2'd0;
            exp_len_reg  <= LEN_NONE;
            sec_min_reg  <= CONT_MIN;
            sec_max_reg  <= CONT_MAX;
            replaced_reg <= 1'b0;
            run_cnt_reg  <= '0;
            run_idx_reg  <= '0;
            run_end_reg  <= 1'b0;
        end else if (s_fire) begin
            held_cnt_reg <= held_cnt_next;
            exp_len_reg  <= exp_len_next;
            sec_min_reg  <= sec_min_next;
            sec_max_reg  <= sec_max_next;
            replaced_reg <= replaced_next;
            run_cnt_reg  <= run_next.cnt;
            run_idx_reg  <= '0;
            run_end_reg  <= s_in_last;
        end else if (m_fire) begin
            run_idx_reg  <= run_idx_reg + RUN_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            held_reg    <= held_next;
            run_ent_reg <= run_next.ent;
        end
    end

endmodule

// File: src/utf8s_checker.sv
// ----------------------------------------------------------------------------
// utf8s_checker
// port-level checks of the utf8 sanitizer, bound to the top level
// ----------------------------------------------------------------------------
`include "utf8_sanitizer_macros.svh"

module utf8s_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_run_last,
    input logic       m_text_end,
    input logic       m_any_replaced
);

    `UTF8S_ASSERT(a_end_on_run_last, aclk, aresetn, m_valid && m_text_end |-> m_run_last, "text end without run last")
    `UTF8S_ASSERT(a_flag_sticky, aclk, aresetn, m_valid && m_ready && !m_text_end && m_any_replaced |=> !m_valid || m_any_replaced, "replacement flag dropped inside a text")
    `UTF8S_ASSERT(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last), "stalled result changed")
    `UTF8S_ASSERT(a_no_take_on_stall, aclk, aresetn, m_valid && !m_ready |-> !s_ready, "request taken while result stalled")
    `UTF8S_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result pending after reset")

endmodule

bind utf8_sanitizer utf8s_checker u_utf8s_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_byte     (m_out_byte),
    .m_run_last     (m_run_last),
    .m_text_end     (m_text_end),
    .m_any_replaced (m_any_replaced)
);
